// ----- rtl/core/pid_deadband_feedforward_defines.svh -----
// Assertion macros for the PID controller with deadband and feedforward.
// Taken in by the top level; no other dependencies.
`ifndef PID_DEADBAND_FEEDFORWARD_DEFINES_SVH
`define PID_DEADBAND_FEEDFORWARD_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PDF_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pdf_pkg.sv -----
// Shared widths, register indexes, stage types and the symmetric clamp
// for the PID controller pipeline. No dependencies.
package pdf_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int GAIN_WIDTH      = 32;
   localparam int GAIN_FRAC_BITS  = 16;
   localparam int ERR_WIDTH       = SAMPLE_WIDTH + 1;
   localparam int ESUM_WIDTH      = 21;
   localparam int EDIFF_WIDTH     = ERR_WIDTH + 1;
   localparam int TDIFF_WIDTH     = SAMPLE_WIDTH + 1;
   localparam int DRIVE_WIDTH     = 16;
   localparam int DBAND_WIDTH     = 16;
   localparam int ILIM_WIDTH      = 20;
   localparam int TLIM_WIDTH      = 15;
   localparam int TERM_WIDTH      = 40;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_GAIN_FF,
      CSR_DEAD_BAND,
      CSR_INTEGRAL_LIMIT,
      CSR_I_TERM_LIMIT,
      CSR_OUTPUT_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] gain_p;
      logic signed [GAIN_WIDTH-1:0] gain_i;
      logic signed [GAIN_WIDTH-1:0] gain_d;
      logic signed [GAIN_WIDTH-1:0] gain_ff;
      logic [DBAND_WIDTH-1:0]       dead_band;
      logic [ILIM_WIDTH-1:0]        integral_limit;
      logic [TLIM_WIDTH-1:0]        i_term_limit;
      logic [TLIM_WIDTH-1:0]        output_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_WIDTH-1:0]   err;
      logic signed [ESUM_WIDTH-1:0]  esum;
      logic signed [EDIFF_WIDTH-1:0] ediff;
      logic signed [TDIFF_WIDTH-1:0] tdiff;
   } front_type;

   typedef struct packed {
      logic signed [TERM_WIDTH-1:0] p;
      logic signed [TERM_WIDTH-1:0] i;
      logic signed [TERM_WIDTH-1:0] d;
      logic signed [TERM_WIDTH-1:0] f;
   } term_type;

   function automatic logic signed [TERM_WIDTH-1:0] clamp_sym(
      input logic signed [TERM_WIDTH-1:0] v,
      input logic [ILIM_WIDTH-1:0]        lim
   );
      logic signed [TERM_WIDTH-1:0] hi;
      logic signed [TERM_WIDTH-1:0] lo;
      hi = signed'(TERM_WIDTH'(lim));
      lo = -hi;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage

// ----- rtl/core/pid_deadband_feedforward.sv -----
// Positional PID controller with error deadband and target feedforward.
// Throughput: one request per cycle while the output is not stalled, through a five-register pipeline
// (input, error/integrator, multipliers, partial sums, result).
// Reset clears gains, limits, integrator, previous error and target, and the pipeline valid flags.
// The whole pipeline holds only while a result waits and rsp_ready is low.
`include "pid_deadband_feedforward_defines.svh"

module pid_deadband_feedforward import pdf_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_target,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_actual,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [DRIVE_WIDTH-1:0]    rsp_drive,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]        csr_wdata
);

   cfg_type                       cfg_ff;
   cfg_type                       cfg_in;
   logic                          advance;
   logic                          front_valid;
   front_type                     front;
   logic                          term_valid;
   term_type                      terms;
   logic signed [DRIVE_WIDTH-1:0] out_lim;
   logic                          req_fire;
   logic                          drive_ok;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:         cfg_in.gain_p  = signed'(csr_wdata[GAIN_WIDTH-1:0]);
            CSR_GAIN_I:         cfg_in.gain_i  = signed'(csr_wdata[GAIN_WIDTH-1:0]);
            CSR_GAIN_D:         cfg_in.gain_d  = signed'(csr_wdata[GAIN_WIDTH-1:0]);
            CSR_GAIN_FF:        cfg_in.gain_ff = signed'(csr_wdata[GAIN_WIDTH-1:0]);
            CSR_DEAD_BAND:      cfg_in.dead_band      = csr_wdata[DBAND_WIDTH-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[ILIM_WIDTH-1:0];
            CSR_I_TERM_LIMIT:   cfg_in.i_term_limit   = csr_wdata[TLIM_WIDTH-1:0];
            CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wdata[TLIM_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_target  (req_target),
      .req_actual  (req_actual),
      .cfg         (cfg_ff),
      .front_valid (front_valid),
      .front       (front)
   );

   pdf_mult u_mult (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .front_valid (front_valid),
      .front       (front),
      .cfg         (cfg_ff),
      .term_valid  (term_valid),
      .terms       (terms)
   );

   pdf_sum u_sum (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .term_valid (term_valid),
      .terms      (terms),
      .cfg        (cfg_ff),
      .rsp_valid  (rsp_valid),
      .rsp_drive  (rsp_drive)
   );

   assign out_lim  = signed'(DRIVE_WIDTH'(cfg_ff.output_limit));
   assign req_fire = req_valid && req_ready;
   assign drive_ok = (rsp_drive <= out_lim) && (rsp_drive >= -out_lim);

   `PDF_ASSERT_HOLDS(a_drive_in_limit, clock, reset, rsp_valid, drive_ok, "drive beyond limit")
   `PDF_ASSERT_NEXT(a_pipe_latency, clock, reset, req_fire ##1 rsp_ready[*4], rsp_valid, "request lost")

endmodule

// ----- rtl/core/pdf_front.sv -----
// Input register, deadband, integrator and difference terms; holds the
// controller state. Depends on pdf_pkg.
module pdf_front import pdf_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           req_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] req_target,
   input  logic signed [SAMPLE_WIDTH-1:0] req_actual,
   input  cfg_type                        cfg,
   output logic                           front_valid,
   output front_type                      front
);

   logic                          in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] tgt_ff;
   logic signed [SAMPLE_WIDTH-1:0] act_ff;
   logic signed [ESUM_WIDTH-1:0]  esum_ff;
   logic signed [ERR_WIDTH-1:0]   perr_ff;
   logic signed [SAMPLE_WIDTH-1:0] ptgt_ff;
   logic                          front_valid_ff;
   front_type                     front_ff;
   front_type                     front_in;

   logic signed [ERR_WIDTH-1:0]   err_raw;
   logic signed [ERR_WIDTH:0]     err_wide;
   logic signed [ERR_WIDTH:0]     band;
   logic signed [ERR_WIDTH-1:0]   err;
   logic signed [TERM_WIDTH-1:0]  esum_acc;
   logic signed [ESUM_WIDTH-1:0]  esum_in;

   always_comb begin
      err_raw  = ERR_WIDTH'(tgt_ff) - ERR_WIDTH'(act_ff);
      err_wide = (ERR_WIDTH + 1)'(err_raw);
      band     = signed'((ERR_WIDTH + 1)'(cfg.dead_band));
      // drop errors strictly inside the deadband
      if ((err_wide > -band) && (err_wide < band)) begin
         err = '0;
      end else begin
         err = err_raw;
      end
      esum_acc       = TERM_WIDTH'(esum_ff) + TERM_WIDTH'(err);
      esum_in        = ESUM_WIDTH'(clamp_sym(esum_acc, cfg.integral_limit));
      front_in.err   = err;
      front_in.esum  = esum_in;
      front_in.ediff = EDIFF_WIDTH'(err) - EDIFF_WIDTH'(perr_ff);
      front_in.tdiff = TDIFF_WIDTH'(tgt_ff) - TDIFF_WIDTH'(ptgt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         front_valid_ff <= 1'b0;
         esum_ff        <= '0;
         perr_ff        <= '0;
         ptgt_ff        <= '0;
      end else if (advance) begin
         in_valid_ff    <= req_valid;
         front_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            esum_ff <= esum_in;
            perr_ff <= err;
            ptgt_ff <= tgt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tgt_ff   <= req_target;
         act_ff   <= req_actual;
         front_ff <= front_in;
      end
   end

   assign front_valid = front_valid_ff;
   assign front       = front_ff;

endmodule

// ----- rtl/core/pdf_mult.sv -----
// Gain multipliers: four products with Q16.16 gains, floored, registered.
// Depends on pdf_pkg.
module pdf_mult import pdf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      front_valid,
   input  front_type front,
   input  cfg_type   cfg,
   output logic      term_valid,
   output term_type  terms
);

   logic                                    term_valid_ff;
   term_type                                terms_ff;
   term_type                                terms_in;
   logic signed [GAIN_WIDTH+ERR_WIDTH-1:0]   prod_p;
   logic signed [GAIN_WIDTH+ESUM_WIDTH-1:0]  prod_i;
   logic signed [GAIN_WIDTH+EDIFF_WIDTH-1:0] prod_d;
   logic signed [GAIN_WIDTH+TDIFF_WIDTH-1:0] prod_f;

   always_comb begin
      prod_p = $signed(cfg.gain_p) * $signed(front.err);
      prod_i = $signed(cfg.gain_i) * $signed(front.esum);
      prod_d = $signed(cfg.gain_d) * $signed(front.ediff);
      prod_f = $signed(cfg.gain_ff) * $signed(front.tdiff);
      // arithmetic shift floors toward minus infinity
      terms_in.p = TERM_WIDTH'(prod_p >>> GAIN_FRAC_BITS);
      terms_in.i = TERM_WIDTH'(prod_i >>> GAIN_FRAC_BITS);
      terms_in.d = TERM_WIDTH'(prod_d >>> GAIN_FRAC_BITS);
      terms_in.f = TERM_WIDTH'(prod_f >>> GAIN_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else if (advance) begin
         term_valid_ff <= front_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         terms_ff <= terms_in;
      end
   end

   assign term_valid = term_valid_ff;
   assign terms      = terms_ff;

endmodule

// ----- rtl/core/pdf_sum.sv -----
// I-term clamp, term summation, output clamp and the result register.
// Depends on pdf_pkg.
module pdf_sum import pdf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          term_valid,
   input  term_type                      terms,
   input  cfg_type                       cfg,
   output logic                          rsp_valid,
   output logic signed [DRIVE_WIDTH-1:0] rsp_drive
);

   logic                          pair_valid_ff;
   logic signed [TERM_WIDTH-1:0]  pi_ff;
   logic signed [TERM_WIDTH-1:0]  df_ff;
   logic signed [TERM_WIDTH-1:0]  pi_in;
   logic signed [TERM_WIDTH-1:0]  df_in;
   logic signed [TERM_WIDTH-1:0]  i_clamped;
   logic signed [TERM_WIDTH-1:0]  total;
   logic                          rsp_valid_ff;
   logic signed [DRIVE_WIDTH-1:0] rsp_drive_ff;
   logic signed [DRIVE_WIDTH-1:0] rsp_drive_in;

   always_comb begin
      i_clamped    = clamp_sym($signed(terms.i), ILIM_WIDTH'(cfg.i_term_limit));
      pi_in        = $signed(terms.p) + i_clamped;
      df_in        = $signed(terms.d) + $signed(terms.f);
      total        = pi_ff + df_ff;
      rsp_drive_in = DRIVE_WIDTH'(clamp_sym(total, ILIM_WIDTH'(cfg.output_limit)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         pair_valid_ff <= term_valid;
         rsp_valid_ff  <= pair_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pi_ff        <= pi_in;
         df_ff        <= df_in;
         rsp_drive_ff <= rsp_drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

// ----- tb/tb_pid_deadband_feedforward.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pid_deadband_feedforward: directed corners, then random samples
// over a sweep of register settings, each drive checked against an in-bench PID predictor.
// Depends on pdf_pkg and the pid_deadband_feedforward RTL.
module tb_pid_deadband_feedforward;
   import pdf_pkg::*;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 200;
   localparam int SMAX           = 32767;
   localparam int SMIN           = -32768;

   class drive_checker;
      logic signed [GAIN_WIDTH-1:0]  kp, ki, kd, kff;
      logic [DBAND_WIDTH-1:0]        band;
      logic [ILIM_WIDTH-1:0]         sum_lim;
      logic [TLIM_WIDTH-1:0]         iterm_lim, drive_lim;
      longint                        err_acc, prev_err, last_tgt;
      logic signed [DRIVE_WIDTH-1:0] expected_drive[$];
      int                            n_checked, n_errors;

      function new();
         kp = '0; ki = '0; kd = '0; kff = '0;
         band = '0; sum_lim = '0; iterm_lim = '0; drive_lim = '0;
         err_acc = 0; prev_err = 0; last_tgt = 0;
         n_checked = 0; n_errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_GAIN_P:         kp = data;
            CSR_GAIN_I:         ki = data;
            CSR_GAIN_D:         kd = data;
            CSR_GAIN_FF:        kff = data;
            CSR_DEAD_BAND:      band = data[DBAND_WIDTH-1:0];
            CSR_INTEGRAL_LIMIT: sum_lim = data[ILIM_WIDTH-1:0];
            CSR_I_TERM_LIMIT:   iterm_lim = data[TLIM_WIDTH-1:0];
            CSR_OUTPUT_LIMIT:   drive_lim = data[TLIM_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // gain * x fits easily in 64 bits; the arithmetic shift floors
      function longint scaled(longint gain, longint x);
         return (gain * x) >>> GAIN_FRAC_BITS;
      endfunction

      function longint clip(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void note_request(logic signed [SAMPLE_WIDTH-1:0] tgt,
                                 logic signed [SAMPLE_WIDTH-1:0] act);
         longint t, e, b, i_part, total;
         t = tgt;
         e = t - longint'(act);
         b = band;
         if (e > -b && e < b) e = 0;
         err_acc = clip(err_acc + e, sum_lim);
         i_part = clip(scaled(ki, err_acc), iterm_lim);
         total = scaled(kp, e) + i_part + scaled(kd, e - prev_err) + scaled(kff, t - last_tgt);
         total = clip(total, drive_lim);
         prev_err = e;
         last_tgt = t;
         expected_drive.push_back(total[DRIVE_WIDTH-1:0]);
      endfunction

      function void check_drive(logic signed [DRIVE_WIDTH-1:0] drive);
         logic signed [DRIVE_WIDTH-1:0] want;
         if (expected_drive.size() == 0) begin
            n_errors++;
            $error("drive: expected no result, actual %0d", drive);
         end else begin
            want = expected_drive.pop_front();
            n_checked++;
            if (drive !== want) begin
               n_errors++;
               $error("drive: expected %0d, actual %0d", want, drive);
            end
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic signed [SAMPLE_WIDTH-1:0]  req_target;
   logic signed [SAMPLE_WIDTH-1:0]  req_actual;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic signed [DRIVE_WIDTH-1:0]   rsp_drive;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]      csr_index;
   logic [CSR_DATA_WIDTH-1:0]       csr_wdata;

   drive_checker tracker = new();
   int n_sent = 0;
   int n_settings = 0;
   int burst_left = 0;
   int ready_hold = 0;
   int cur_band = 0;
   int walk = 0;
   int cycle_count = 0;

   pid_deadband_feedforward DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_target (req_target),
      .req_actual (req_actual),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_drive  (rsp_drive),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // check before noting, so a stray result never consumes a fresh request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_drive(rsp_drive);
         if (csr_valid && csr_ready) tracker.write_reg(csr_index_type'(csr_index), csr_wdata);
         if (req_valid && req_ready) tracker.note_request(req_target, req_actual);
      end
   end

   // receiver: open stretches, stall stretches and cycle-by-cycle dither
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case ($urandom_range(3))
            0: begin
               rsp_ready <= 1'b1;
               ready_hold <= $urandom_range(0, 40);
            end
            1: begin
               rsp_ready <= 1'b0;
               ready_hold <= $urandom_range(0, 12);
            end
            default: rsp_ready <= 1'($urandom_range(1));
         endcase
      end
   end

   function automatic int sat16(int v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic int corner_value();
      case ($urandom_range(4))
         0: return SMIN;
         1: return SMAX;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic logic [GAIN_WIDTH-1:0] pick_gain();
      logic [GAIN_WIDTH-1:0] v;
      case ($urandom_range(7))
         0: return '0;
         1: return $urandom;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: begin
            // realistic gains, up to about four
            v = $urandom_range(0, 32'h0004_0000);
            return $urandom_range(1) ? -v : v;
         end
      endcase
   endfunction

   function automatic int pick_limit(int top);
      case ($urandom_range(7))
         0: return 0;
         1: return top;
         2, 3: return $urandom_range(0, top);
         default: return $urandom_range(0, top / 4);
      endcase
   endfunction

   function automatic int pick_band();
      case ($urandom_range(5))
         0: return 0;
         1: return $urandom_range(0, 65535);
         2: return 65535;
         default: return $urandom_range(1, 200);
      endcase
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_setting(logic [GAIN_WIDTH-1:0] p, logic [GAIN_WIDTH-1:0] i,
                                logic [GAIN_WIDTH-1:0] d, logic [GAIN_WIDTH-1:0] ff,
                                int db, int il, int tl, int ol);
      req_valid <= 1'b0;
      burst_left = 0;
      // registers change only once every drive has come back
      while (tracker.n_checked < n_sent) @(posedge clock);
      write_reg(CSR_GAIN_P, p);
      write_reg(CSR_GAIN_I, i);
      write_reg(CSR_GAIN_D, d);
      write_reg(CSR_GAIN_FF, ff);
      write_reg(CSR_DEAD_BAND, db);
      write_reg(CSR_INTEGRAL_LIMIT, il);
      write_reg(CSR_I_TERM_LIMIT, tl);
      write_reg(CSR_OUTPUT_LIMIT, ol);
      csr_valid <= 1'b0;
      cur_band = db;
      n_settings++;
   endtask

   task automatic send_sample(int tgt, int act);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_target <= tgt[SAMPLE_WIDTH-1:0];
      req_actual <= act[SAMPLE_WIDTH-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_random_sample();
      int t, a, span;
      case ($urandom_range(9))
         0, 1: begin
            t = $urandom_range(0, 65535) - 32768;
            a = $urandom_range(0, 65535) - 32768;
         end
         2: begin
            t = corner_value();
            a = corner_value();
         end
         3: begin
            // sit on the deadband edge or one either side of it
            walk = sat16(walk + $urandom_range(0, 600) - 300);
            t = walk;
            a = sat16(walk + ($urandom_range(1) ? cur_band : -cur_band)
                      + $urandom_range(0, 2) - 1);
         end
         default: begin
            // slow set point with the measurement tracking around it
            walk = sat16(walk + $urandom_range(0, 600) - 300);
            span = cur_band + 16;
            t = walk;
            a = sat16(walk + $urandom_range(0, 2 * span) - span);
         end
      endcase
      send_sample(t, a);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL pid_deadband_feedforward");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_target <= '0;
      req_actual <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_GAIN_P;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: zero limits hold the drive at zero
      send_sample(SMAX, SMIN);
      send_sample(SMIN, SMAX);
      send_sample(1234, -77);

      // moderate gains, deadband edges and full-scale errors
      apply_setting(32'h0001_0000, 32'h0000_8000, 32'hFFFF_C000, 32'h0001_8000,
                    100, 5000, 2000, 32767);
      send_sample(100, 0);
      send_sample(-50, 50);
      send_sample(99, 0);
      send_sample(0, 99);
      send_sample(7, 7);
      send_sample(SMAX, SMIN);
      send_sample(SMIN, SMAX);
      send_sample(SMIN, SMIN);
      send_sample(SMAX, SMAX);

      // extreme gains with no deadband: exact products, only clamps bound them
      apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    0, 1048575, 32767, 32767);
      send_sample(1, 0);
      send_sample(0, 0);
      send_sample(SMAX, SMIN);
      send_sample(SMIN, SMAX);
      send_sample(-1, 0);

      // widest deadband, zero integral clamps, tiny gains to expose flooring
      apply_setting(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001,
                    65535, 0, 0, 32767);
      send_sample(SMAX, SMIN);
      send_sample(SMIN, SMAX);
      send_sample(100, -200);
      send_sample(5, 5);

      // zero output limit against large gains
      apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    0, 1048575, 32767, 0);
      send_sample(SMAX, SMIN);
      send_sample(SMIN, 0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_band(),
                       pick_limit(1048575), pick_limit(32767), pick_limit(32767));
         for (int n = 0; n < PHASE_REQUESTS; n++) send_random_sample();
      end

      req_valid <= 1'b0;
      while (tracker.n_checked < n_sent) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d samples under %0d register settings; %0d drives compared.",
               n_sent, n_settings, tracker.n_checked);
      if (tracker.n_errors == 0 && tracker.expected_drive.size() == 0) begin
         $display("PASS pid_deadband_feedforward");
      end else begin
         $display("FAIL pid_deadband_feedforward");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pdf_pkg.sv
rtl/core/pdf_front.sv
rtl/core/pdf_mult.sv
rtl/core/pdf_sum.sv
rtl/core/pid_deadband_feedforward.sv
tb/tb_pid_deadband_feedforward.sv
